>>> rtl/tcp_server_session_fsm_defines.svh
// ============================================================================
// tcp_server_session_fsm_defines: assertion macros for the session engine
// Shared property wrappers; all sample on clk and hold off during reset.
// ============================================================================
`ifndef TCP_SERVER_SESSION_FSM_DEFINES_SVH
`define TCP_SERVER_SESSION_FSM_DEFINES_SVH

// Same-cycle implication.
`define TCPSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCPSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tcpss_pkg.sv
// ============================================================================
// tcpss_pkg: shared types and constants
// Session state codes, flag masks, result codes and beat structures.
// ============================================================================
package tcpss_pkg;

    typedef enum logic [2:0] {
        ST_CLOSED      = 3'd0,
        ST_LISTEN      = 3'd1,
        ST_SYN_SEEN    = 3'd2,
        ST_ESTABLISHED = 3'd3,
        ST_FIN_SENT    = 3'd4
    } conn_state_t;

    localparam logic [5:0] F_URG = 6'h20;
    localparam logic [5:0] F_ACK = 6'h10;
    localparam logic [5:0] F_PSH = 6'h08;
    localparam logic [5:0] F_RST = 6'h04;
    localparam logic [5:0] F_SYN = 6'h02;
    localparam logic [5:0] F_FIN = 6'h01;

    localparam logic [1:0] ACT_DROP   = 2'd0;
    localparam logic [1:0] ACT_IGNORE = 2'd1;
    localparam logic [1:0] ACT_SEND   = 2'd2;

    localparam logic [1:0] BODY_NONE = 2'd0;
    localparam logic [1:0] BODY_OK   = 2'd1;
    localparam logic [1:0] BODY_ERR  = 2'd2;

    localparam logic [1:0] CFG_INITIAL_SEQ  = 2'd0;
    localparam logic [1:0] CFG_SERVICE_PORT = 2'd1;
    localparam logic [1:0] CFG_OK_BODY_LEN  = 2'd2;
    localparam logic [1:0] CFG_ERR_BODY_LEN = 2'd3;

    localparam logic [31:0] INITIAL_SEQ_RST  = 32'd81;
    localparam logic [15:0] SERVICE_PORT_RST = 16'd80;
    localparam logic [15:0] OK_BODY_LEN_RST  = 16'd81;
    localparam logic [15:0] ERR_BODY_LEN_RST = 16'd80;

    typedef struct packed {
        logic        frame_ok;
        logic [15:0] dst_port;
        logic [5:0]  tcp_flags;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack;
        logic [15:0] payload_len;
        logic        is_get;
    } seg_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  out_flags;
        logic [31:0] out_seq;
        logic [31:0] out_ack;
        logic [1:0]  body_sel;
        logic [15:0] body_len;
        logic        last;
    } res_t;

    typedef struct packed {
        conn_state_t conn_state;
        logic [31:0] own_seq;
        logic [31:0] peer_ack_num;
        logic [31:0] expected_ack;
    } sess_t;

    typedef struct packed {
        logic [31:0] initial_seq;
        logic [15:0] service_port;
        logic [15:0] ok_body_len;
        logic [15:0] err_body_len;
    } cfg_t;

    // Control from the top level to the result register.
    typedef struct packed {
        logic load;
        logic fin_pair;
    } outreg_ctl_t;

endpackage

>>> rtl/tcpss_decide.sv
// ============================================================================
// tcpss_decide: per-segment decision logic
// Classifies one registered segment against the session and builds the reply.
// ============================================================================
module tcpss_decide (
    input  tcpss_pkg::seg_t  seg,
    input  tcpss_pkg::sess_t sess,
    input  tcpss_pkg::cfg_t  cfg,
    output tcpss_pkg::res_t  res,
    output logic             fin_pair,
    output tcpss_pkg::sess_t sess_upd
);
    import tcpss_pkg::*;

    logic        addr_ok;
    logic [15:0] page_len;
    logic [1:0]  page_sel;
    logic [31:0] seq_plus_one;

    assign addr_ok      = seg.frame_ok && (seg.dst_port == cfg.service_port);
    assign page_len     = seg.is_get ? cfg.ok_body_len : cfg.err_body_len;
    assign page_sel     = seg.is_get ? BODY_OK : BODY_ERR;
    assign seq_plus_one = seg.seg_seq + 32'd1;

    always_comb
    begin
        sess_upd = sess;
        fin_pair = 1'b0;
        res      = '{action: ACT_DROP, out_flags: 6'd0, out_seq: 32'd0,
                     out_ack: 32'd0, body_sel: BODY_NONE, body_len: 16'd0,
                     last: 1'b1};
        if (addr_ok)
        begin
            unique case (sess.conn_state)
                ST_LISTEN:
                begin
                    if (seg.tcp_flags == F_SYN)
                    begin
                        sess_upd.peer_ack_num = seq_plus_one;
                        sess_upd.expected_ack = sess.own_seq + 32'd1;
                        sess_upd.conn_state   = ST_SYN_SEEN;
                        res.action            = ACT_SEND;
                        res.out_flags         = F_SYN | F_ACK;
                        res.out_seq           = sess.own_seq;
                        res.out_ack           = seq_plus_one;
                    end
                end
                ST_SYN_SEEN:
                begin
                    if (seg.tcp_flags == F_ACK && seg.seg_ack == sess.expected_ack)
                    begin
                        sess_upd.conn_state = ST_ESTABLISHED;
                        res.action          = ACT_IGNORE;
                    end
                end
                ST_ESTABLISHED:
                begin
                    if (seg.tcp_flags[0])
                    begin
                        // FIN: ACK now, FIN+ACK follows from the result register
                        sess_upd.own_seq      = seg.seg_ack;
                        sess_upd.peer_ack_num = seq_plus_one;
                        sess_upd.conn_state   = ST_FIN_SENT;
                        fin_pair              = 1'b1;
                        res.action            = ACT_SEND;
                        res.out_flags         = F_ACK;
                        res.out_seq           = seg.seg_ack;
                        res.out_ack           = seq_plus_one;
                        res.last              = 1'b0;
                    end
                    else if (seg.tcp_flags == (F_PSH | F_ACK))
                    begin
                        sess_upd.peer_ack_num = seg.seg_seq + {16'd0, seg.payload_len};
                        sess_upd.own_seq      = seg.seg_ack;
                        sess_upd.expected_ack = seg.seg_ack + {16'd0, page_len};
                        res.action            = ACT_SEND;
                        res.out_flags         = F_ACK;
                        res.out_seq           = seg.seg_ack;
                        res.out_ack           = seg.seg_seq + {16'd0, seg.payload_len};
                        res.body_sel          = page_sel;
                        res.body_len          = page_len;
                    end
                    else
                    begin
                        res.action = ACT_IGNORE;
                    end
                end
                ST_FIN_SENT:
                begin
                    if (seg.tcp_flags == F_ACK && seg.seg_seq == sess.peer_ack_num &&
                        seg.seg_ack == sess.own_seq)
                    begin
                        sess_upd.conn_state = ST_CLOSED;
                    end
                    res.action = ACT_IGNORE;
                end
                default:
                begin
                    res.action = ACT_IGNORE;
                end
            endcase
        end
    end

endmodule

>>> rtl/tcpss_out_reg.sv
// ============================================================================
// tcpss_out_reg: result register
// Holds one result beat; replays a FIN reply as a second FIN+ACK beat.
// ============================================================================
module tcpss_out_reg (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tcpss_pkg::outreg_ctl_t ctl,
    input  tcpss_pkg::res_t        res_in,
    output logic                   can_load,
    output logic                   res_valid,
    input  logic                   res_stall,
    output tcpss_pkg::res_t        res_out
);
    import tcpss_pkg::*;

    logic valid_reg;
    logic valid_next;
    logic pend_reg;
    logic pend_next;
    res_t res_reg;
    res_t res_next;
    logic taken;

    assign taken    = valid_reg && !res_stall;
    assign can_load = !pend_reg && (!valid_reg || !res_stall);

    always_comb
    begin
        valid_next = valid_reg;
        pend_next  = pend_reg;
        res_next   = res_reg;
        if (ctl.load)
        begin
            valid_next = 1'b1;
            pend_next  = ctl.fin_pair;
            res_next   = res_in;
        end
        else if (taken && pend_reg)
        begin
            pend_next          = 1'b0;
            res_next.out_flags = F_FIN | F_ACK;
            res_next.last      = 1'b1;
        end
        else if (taken)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

>>> rtl/tcp_server_session_fsm.sv
// ============================================================================
// tcp_server_session_fsm: passive single-connection TCP server session engine
// Path: the segment beat lands in the input reg, then moves to the result reg.
// Throughput: 1 segment/cycle unless stalled; a FIN gives a second beat (FIN+ACK).
// Reset: async active-low; LISTEN, own seq 81, port 80, page lengths 81/80, empty.
// ============================================================================
module tcp_server_session_fsm (
    input  logic        clk,
    input  logic        rst_n,

    // Segment channel
    input  logic        seg_valid,
    output logic        seg_stall,
    input  logic        frame_ok,
    input  logic [15:0] dst_port,
    input  logic [5:0]  tcp_flags,
    input  logic [31:0] seg_seq,
    input  logic [31:0] seg_ack,
    input  logic [15:0] payload_len,
    input  logic        is_get,

    // Result channel
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  action,
    output logic [5:0]  out_flags,
    output logic [31:0] out_seq,
    output logic [31:0] out_ack,
    output logic [1:0]  body_sel,
    output logic [15:0] body_len,
    output logic        last,

    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import tcpss_pkg::*;

    // ------------------------------------------------------------------
    // Datapath overview
    //   segment beat -> input register -> decide logic -> result register
    // Session state (connection state and sequence bookkeeping) is
    // updated at the same edge that moves a segment from the input
    // register into the result register, so the next segment, held behind
    // it in the input register, always sees the updated session.
    // ------------------------------------------------------------------

    logic        seg_valid_reg;
    logic        seg_valid_next;
    seg_t        seg_reg;
    sess_t       sess_reg;
    sess_t       sess_next;
    sess_t       sess_upd;
    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    res_t        res_dec;
    res_t        res_q;
    logic        fin_pair;
    logic        can_load;
    logic        move;
    logic        seg_take;
    logic        cfg_take;
    outreg_ctl_t out_ctl;

    // ------------------------------------------------------------------
    // Input register. The segment advances whenever the result register
    // can take it; stall only while a held segment is blocked.
    // ------------------------------------------------------------------
    assign move      = seg_valid_reg && can_load;
    assign seg_stall = seg_valid_reg && !can_load;
    assign seg_take  = seg_valid && !seg_stall;

    always_comb
    begin
        seg_valid_next = seg_valid_reg;
        if (seg_take)
        begin
            seg_valid_next = 1'b1;
        end
        else if (move)
        begin
            seg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_valid_reg <= 1'b0;
        end
        else
        begin
            seg_valid_reg <= seg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_take)
        begin
            seg_reg <= '{frame_ok: frame_ok, dst_port: dst_port, tcp_flags: tcp_flags,
                         seg_seq: seg_seq, seg_ack: seg_ack,
                         payload_len: payload_len, is_get: is_get};
        end
    end

    // ------------------------------------------------------------------
    // Config registers. Always ready; writes must arrive while idle, unchecked.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_take)
        begin
            unique case (cfg_index)
                CFG_INITIAL_SEQ:  cfg_next.initial_seq  = cfg_data;
                CFG_SERVICE_PORT: cfg_next.service_port = cfg_data[15:0];
                CFG_OK_BODY_LEN:  cfg_next.ok_body_len  = cfg_data[15:0];
                CFG_ERR_BODY_LEN: cfg_next.err_body_len = cfg_data[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{initial_seq: INITIAL_SEQ_RST, service_port: SERVICE_PORT_RST,
                         ok_body_len: OK_BODY_LEN_RST, err_body_len: ERR_BODY_LEN_RST};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ------------------------------------------------------------------
    // Session state. A new initial sequence written while listening is
    // also taken as the current own sequence number.
    // ------------------------------------------------------------------
    tcpss_decide u_decide (
        .seg      (seg_reg),
        .sess     (sess_reg),
        .cfg      (cfg_reg),
        .res      (res_dec),
        .fin_pair (fin_pair),
        .sess_upd (sess_upd)
    );

    always_comb
    begin
        sess_next = sess_reg;
        if (move)
        begin
            sess_next = sess_upd;
        end
        else if (cfg_take && cfg_index == CFG_INITIAL_SEQ &&
                 sess_reg.conn_state == ST_LISTEN)
        begin
            sess_next.own_seq = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sess_reg <= '{conn_state: ST_LISTEN, own_seq: INITIAL_SEQ_RST,
                          peer_ack_num: 32'd0, expected_ack: 32'd0};
        end
        else
        begin
            sess_reg <= sess_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register. A FIN reply keeps it busy for a second beat
    // (FIN+ACK); can_load is low until the first beat (ACK) is taken.
    // ------------------------------------------------------------------
    assign out_ctl = '{load: move, fin_pair: fin_pair};

    tcpss_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (out_ctl),
        .res_in    (res_dec),
        .can_load  (can_load),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_out   (res_q)
    );

    assign action    = res_q.action;
    assign out_flags = res_q.out_flags;
    assign out_seq   = res_q.out_seq;
    assign out_ack   = res_q.out_ack;
    assign body_sel  = res_q.body_sel;
    assign body_len  = res_q.body_len;
    assign last      = res_q.last;

endmodule

>>> rtl/tcpss_checker.sv
// ============================================================================
// tcpss_checker: port-level checks for tcp_server_session_fsm
// Watches the result channel; attached to the top level by bind.
// ============================================================================
`include "tcp_server_session_fsm_defines.svh"

module tcpss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_stall,
    input logic [1:0]  action,
    input logic [5:0]  out_flags,
    input logic [31:0] out_seq,
    input logic [31:0] out_ack,
    input logic [1:0]  body_sel,
    input logic [15:0] body_len,
    input logic        last
);
    import tcpss_pkg::*;

    `TCPSS_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(action) && $stable(out_flags) && $stable(out_seq) && $stable(out_ack) && $stable(last), "result beat changed while stalled")

    `TCPSS_ASSERT_NOW(a_nosend_clean, res_valid && action != ACT_SEND, out_flags == 6'd0 && out_seq == 32'd0 && out_ack == 32'd0 && body_sel == BODY_NONE && body_len == 16'd0 && last, "drop or ignore beat carries reply fields")

    `TCPSS_ASSERT_NOW(a_first_of_pair, res_valid && !last, action == ACT_SEND && out_flags == F_ACK && body_sel == BODY_NONE, "non-final beat is not a bare ACK")

    `TCPSS_ASSERT_NEXT(a_fin_follows, res_valid && !res_stall && !last, res_valid && last && out_flags == (F_FIN | F_ACK) && out_seq == $past(out_seq) && out_ack == $past(out_ack), "FIN+ACK does not follow the ACK")

endmodule

bind tcp_server_session_fsm tcpss_checker u_tcpss_checker (.*);

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the passive TCP server session engine
// Segment beats are driven through the valid/stall channel and checked against
// a behavioral session model. The run walks the whole connection lifecycle
// once: listen, SYN seen, established (bulk random traffic), FIN sent, closed.
// ----------------------------------------------------------------------------
module testbench;
    import tcpss_pkg::*;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT pins. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        seg_valid = 1'b0;
    logic        seg_stall;
    logic        frame_ok = 1'b0;
    logic [15:0] dst_port = '0;
    logic [5:0]  tcp_flags = '0;
    logic [31:0] seg_seq = '0;
    logic [31:0] seg_ack = '0;
    logic [15:0] payload_len = '0;
    logic        is_get = 1'b0;

    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [1:0]  action;
    logic [5:0]  out_flags;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic [1:0]  body_sel;
    logic [15:0] body_len;
    logic        last;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    always #5 clk = ~clk;

    tcp_server_session_fsm dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .seg_valid   (seg_valid),
        .seg_stall   (seg_stall),
        .frame_ok    (frame_ok),
        .dst_port    (dst_port),
        .tcp_flags   (tcp_flags),
        .seg_seq     (seg_seq),
        .seg_ack     (seg_ack),
        .payload_len (payload_len),
        .is_get      (is_get),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .action      (action),
        .out_flags   (out_flags),
        .out_seq     (out_seq),
        .out_ack     (out_ack),
        .body_sel    (body_sel),
        .body_len    (body_len),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Session model state: registers plus connection context, mirrored from
    // the reset values in the package.
    // ------------------------------------------------------------------------
    logic [31:0] cfg_initial_seq = INITIAL_SEQ_RST;
    logic [15:0] cfg_port        = SERVICE_PORT_RST;
    logic [15:0] cfg_ok_len      = OK_BODY_LEN_RST;
    logic [15:0] cfg_err_len     = ERR_BODY_LEN_RST;

    conn_state_t sess_state      = ST_LISTEN;
    logic [31:0] sess_own_seq    = INITIAL_SEQ_RST;
    logic [31:0] sess_peer_ack   = '0;
    logic [31:0] sess_expect_ack = '0;

    res_t pending_replies[$];   // reply beats predicted but not yet seen
    int   fail_count = 0;

    // Idle behavior, in percent of cycles; changed per traffic phase.
    int   send_idle_pct  = 18;
    int   recv_stall_pct = 63;

    function automatic string format_reply(input res_t r);
        return $sformatf("act=%0d flags=%h seq=%h ack=%h sel=%0d len=%0d last=%0b",
                         r.action, r.out_flags, r.out_seq, r.out_ack,
                         r.body_sel, r.body_len, r.last);
    endfunction

    // Only the first ten failures are printed; the rest are just counted.
    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] ERROR: %s", $realtime, msg);
    endfunction

    // ------------------------------------------------------------------------
    // Reply prediction. Called once per accepted segment beat; queues one or
    // two reply beats and advances the session context.
    // ------------------------------------------------------------------------
    function automatic void predict_replies(input seg_t s);
        res_t r;
        r        = '0;
        r.last   = 1'b1;
        r.action = ACT_DROP;
        // Frame check and port filter apply in every state, closed included.
        if (!s.frame_ok || s.dst_port != cfg_port)
        begin
            pending_replies.push_back(r);
            return;
        end
        case (sess_state)
            ST_LISTEN:
            begin
                // Only a pure SYN opens the connection.
                if (s.tcp_flags == F_SYN)
                begin
                    sess_peer_ack   = s.seg_seq + 32'd1;
                    sess_expect_ack = sess_own_seq + 32'd1;
                    sess_state      = ST_SYN_SEEN;
                    r.action        = ACT_SEND;
                    r.out_flags     = F_SYN | F_ACK;
                    r.out_seq       = sess_own_seq;
                    r.out_ack       = sess_peer_ack;
                end
            end
            ST_SYN_SEEN:
            begin
                if (s.tcp_flags == F_ACK && s.seg_ack == sess_expect_ack)
                begin
                    sess_state = ST_ESTABLISHED;
                    r.action   = ACT_IGNORE;
                end
            end
            ST_ESTABLISHED:
            begin
                r.action = ACT_IGNORE;
                if ((s.tcp_flags & F_FIN) != '0)
                begin
                    // Close request: ACK beat then FIN+ACK beat, same numbers.
                    sess_own_seq  = s.seg_ack;
                    sess_peer_ack = s.seg_seq + 32'd1;
                    sess_state    = ST_FIN_SENT;
                    r.action      = ACT_SEND;
                    r.out_flags   = F_ACK;
                    r.out_seq     = sess_own_seq;
                    r.out_ack     = sess_peer_ack;
                    r.last        = 1'b0;
                    pending_replies.push_back(r);
                    r.out_flags   = F_FIN | F_ACK;
                    r.last        = 1'b1;
                end
                else if (s.tcp_flags == (F_PSH | F_ACK))
                begin
                    r.action        = ACT_SEND;
                    r.out_flags     = F_ACK;
                    r.body_sel      = s.is_get ? BODY_OK : BODY_ERR;
                    r.body_len      = s.is_get ? cfg_ok_len : cfg_err_len;
                    sess_peer_ack   = s.seg_seq + 32'(s.payload_len);
                    sess_own_seq    = s.seg_ack;
                    sess_expect_ack = sess_own_seq + 32'(r.body_len);
                    r.out_seq       = sess_own_seq;
                    r.out_ack       = sess_peer_ack;
                end
            end
            ST_FIN_SENT:
            begin
                if (s.tcp_flags == F_ACK && s.seg_seq == sess_peer_ack &&
                    s.seg_ack == sess_own_seq)
                    sess_state = ST_CLOSED;
                r.action = ACT_IGNORE;
            end
            default: r.action = ACT_IGNORE;
        endcase
        pending_replies.push_back(r);
    endfunction

    // ------------------------------------------------------------------------
    // Reply side: checks every accepted reply beat against the oldest
    // prediction, then picks the stall for the next cycle.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : reply_check
        res_t got;
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            got = {action, out_flags, out_seq, out_ack, body_sel, body_len, last};
            if (pending_replies.size() == 0)
            begin
                note_failure({"reply beat with nothing expected: ", format_reply(got)});
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got.action !== want.action || got.out_flags !== want.out_flags ||
                    got.out_seq !== want.out_seq || got.out_ack !== want.out_ack ||
                    got.body_sel !== want.body_sel || got.body_len !== want.body_len ||
                    got.last !== want.last)
                    note_failure({"reply mismatch\n  expected ", format_reply(want),
                                  "\n  actual   ", format_reply(got)});
            end
        end
        res_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Segment side. Entered on a rising edge; may idle at random first, then
    // holds the beat until it is taken. Valid stays high after acceptance so
    // back-to-back beats need no extra edge.
    // ------------------------------------------------------------------------
    task automatic send_segment(input seg_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            seg_valid <= 1'b0;
            @(posedge clk);
        end
        seg_valid <= 1'b1;
        {frame_ok, dst_port, tcp_flags, seg_seq, seg_ack, payload_len, is_get} <= s;
        do @(posedge clk); while (seg_stall);
        predict_replies(s);
    endtask

    function automatic seg_t build_segment(input logic ok, input logic [15:0] port,
                                           input logic [5:0] flags,
                                           input logic [31:0] seq, input logic [31:0] ack,
                                           input logic [15:0] len, input logic get);
        seg_t s;
        s = {ok, port, flags, seq, ack, len, get};
        return s;
    endfunction

    // Drops valid and waits for every predicted beat, then for the pipeline
    // to empty. Bounded so a lost beat cannot hang the run.
    task automatic drain_replies();
        int guard;
        guard = 0;
        seg_valid <= 1'b0;
        while (pending_replies.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    // Register write, only ever issued with the engine idle.
    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        drain_replies();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_INITIAL_SEQ:
            begin
                cfg_initial_seq = data;
                // own seq only follows the register while still listening
                if (sess_state == ST_LISTEN)
                    sess_own_seq = data;
            end
            CFG_SERVICE_PORT: cfg_port    = data[15:0];
            CFG_OK_BODY_LEN:  cfg_ok_len  = data[15:0];
            CFG_ERR_BODY_LEN: cfg_err_len = data[15:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Listen: everything but a pure SYN on the service port is dropped.
    // The initial sequence write here also moves own seq; the all-ones value
    // makes the expected ack wrap to zero.
    // ------------------------------------------------------------------------
    task automatic test_listen_handshake();
        send_segment(build_segment(1'b0, 16'd80, F_SYN, 32'h0, 32'h0, 16'd0, 1'b0));
        send_segment(build_segment(1'b1, 16'd81, F_SYN, 32'h0, 32'h0, 16'd0, 1'b0));
        send_segment(build_segment(1'b1, 16'd80, F_ACK, 32'h1, 32'h2, 16'd0, 1'b0));
        send_segment(build_segment(1'b1, 16'd80, F_SYN | F_ACK, 32'h1, 32'h2, 16'd0, 1'b1));
        send_segment(build_segment(1'b1, 16'd80, 6'h3F, '1, '1, '1, 1'b1));
        write_register(CFG_INITIAL_SEQ, 32'hFFFF_FFFF);
        write_register(CFG_SERVICE_PORT, 32'h0000_FFFF);
        // old port is now wrong
        send_segment(build_segment(1'b1, 16'd80, F_SYN, 32'h5, 32'h0, 16'd0, 1'b0));
        // peer seq all ones: ack number wraps to zero
        send_segment(build_segment(1'b1, 16'hFFFF, F_SYN, 32'hFFFF_FFFF, 32'h0, 16'd0, 1'b0));
    endtask

    // ------------------------------------------------------------------------
    // SYN seen: repeated SYN, wrong ack, non-pure ACK are dropped; the
    // matching pure ACK opens the session with no reply.
    // ------------------------------------------------------------------------
    task automatic test_syn_received();
        write_register(CFG_INITIAL_SEQ, 32'h0000_1234);   // register only now
        send_segment(build_segment(1'b1, cfg_port, F_SYN, 32'h7, 32'h0, 16'd0, 1'b0));
        send_segment(build_segment(1'b1, cfg_port, F_ACK, 32'h0, sess_expect_ack + 32'd1,
                                   16'd0, 1'b0));
        send_segment(build_segment(1'b1, cfg_port, F_ACK | F_PSH, 32'h0, sess_expect_ack,
                                   16'd0, 1'b1));
        send_segment(build_segment(1'b0, cfg_port, F_ACK, 32'h0, sess_expect_ack,
                                   16'd0, 1'b0));
        send_segment(build_segment(1'b1, cfg_port, F_ACK, 32'h0, sess_expect_ack,
                                   16'd0, 1'b0));
    endtask

    // ------------------------------------------------------------------------
    // Established, directed: both pages, payload extremes with seq wrap, several
    // flag patterns that must be ignored, then page length and port extremes.
    // ------------------------------------------------------------------------
    task automatic test_established_pages();
        send_segment(build_segment(1'b1, cfg_port, F_PSH | F_ACK, 32'h100, 32'h200,
                                   16'd0, 1'b1));
        send_segment(build_segment(1'b1, cfg_port, F_PSH | F_ACK, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF, 16'hFFFF, 1'b0));
        send_segment(build_segment(1'b1, cfg_port, F_ACK, 32'h1, 32'h1, 16'd4, 1'b1));
        send_segment(build_segment(1'b1, cfg_port, F_PSH, 32'h1, 32'h1, 16'd4, 1'b1));
        send_segment(build_segment(1'b1, cfg_port, F_URG | F_PSH | F_ACK, 32'h1, 32'h1,
                                   16'd4, 1'b1));
        send_segment(build_segment(1'b1, cfg_port, F_RST, 32'h1, 32'h1, 16'd0, 1'b0));
        send_segment(build_segment(1'b1, cfg_port, F_SYN, 32'h1, 32'h1, 16'd0, 1'b0));
        write_register(CFG_OK_BODY_LEN, 32'h0);
        write_register(CFG_ERR_BODY_LEN, 32'hFFFF);
        write_register(CFG_SERVICE_PORT, 32'h0);
        send_segment(build_segment(1'b1, 16'd0, F_PSH | F_ACK, 32'h10, 32'h20, 16'd9, 1'b1));
        send_segment(build_segment(1'b1, 16'd0, F_PSH | F_ACK, 32'h30, 32'hFFFF_FFF0,
                                   16'd9, 1'b0));
    endtask

    // ------------------------------------------------------------------------
    // Established, random traffic. Three idle phases (sender-heavy stall on the
    // reply side, the reverse, then no idling), each split into chunks with a
    // register change between them. Most beats are well-formed PSH+ACK
    // requests; the rest are odd flags, bad frames and foreign ports. FIN is
    // kept out of accepted-port beats so the session stays open.
    // ------------------------------------------------------------------------
    task automatic test_random_traffic();
        seg_t s;
        int   pick;
        int   sel;
        logic [31:0] data;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 18;
                    recv_stall_pct = 63;
                end
                1:
                begin
                    send_idle_pct  = 63;
                    recv_stall_pct = 18;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int chunk = 0; chunk < 3; chunk++)
            begin
                // one register per chunk, extremes about half the time
                sel = $urandom_range(3);
                case ($urandom_range(3))
                    0: data = '0;
                    1: data = '1;
                    default: data = $urandom;
                endcase
                write_register(2'(sel), data);
                repeat (80)
                begin
                    s.frame_ok    = 1'b1;
                    s.dst_port    = cfg_port;
                    s.tcp_flags   = F_PSH | F_ACK;
                    s.seg_seq     = $urandom;
                    s.seg_ack     = $urandom;
                    s.payload_len = ($urandom_range(3) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(1460));
                    s.is_get      = 1'($urandom_range(1));
                    pick = $urandom_range(99);
                    if (pick < 15)
                    begin
                        s.tcp_flags = 6'($urandom_range(63)) & ~F_FIN;
                    end
                    else if (pick < 25)
                    begin
                        s.frame_ok  = 1'b0;
                        s.dst_port  = 16'($urandom);
                        s.tcp_flags = 6'($urandom_range(63));
                    end
                    else if (pick < 35)
                    begin
                        s.dst_port  = cfg_port ^ 16'($urandom_range(65535, 1));
                        s.tcp_flags = 6'($urandom_range(63));
                    end
                    send_segment(s);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Teardown: FIN gives the ACK / FIN+ACK pair, the FIN-sent state ignores
    // anything but the exact closing ACK, and closed ignores everything after.
    // ------------------------------------------------------------------------
    task automatic test_teardown();
        send_segment(build_segment(1'b1, cfg_port, 6'($urandom_range(63)) | F_FIN,
                                   $urandom, $urandom, 16'($urandom), 1'b1));
        send_segment(build_segment(1'b1, cfg_port, F_ACK, sess_peer_ack + 32'd1,
                                   sess_own_seq, 16'd0, 1'b0));
        send_segment(build_segment(1'b1, cfg_port, F_ACK, sess_peer_ack,
                                   sess_own_seq ^ 32'd1, 16'd0, 1'b0));
        send_segment(build_segment(1'b1, cfg_port, F_ACK | F_PSH, sess_peer_ack,
                                   sess_own_seq, 16'd0, 1'b0));
        send_segment(build_segment(1'b0, cfg_port, F_ACK, sess_peer_ack,
                                   sess_own_seq, 16'd0, 1'b0));
        send_segment(build_segment(1'b1, cfg_port ^ 16'd1, F_ACK, sess_peer_ack,
                                   sess_own_seq, 16'd0, 1'b0));
        write_register(CFG_INITIAL_SEQ, $urandom);         // no effect on own seq
        send_segment(build_segment(1'b1, cfg_port, F_ACK, sess_peer_ack,
                                   sess_own_seq, 16'd0, 1'b0));
        // closed for good
        send_segment(build_segment(1'b1, cfg_port, F_SYN, 32'h0, 32'h0, 16'd0, 1'b0));
        send_segment(build_segment(1'b1, cfg_port, F_PSH | F_ACK, 32'h0, 32'h0,
                                   16'd10, 1'b1));
        send_segment(build_segment(1'b1, cfg_port, F_FIN | F_ACK, 32'h0, 32'h0,
                                   16'd0, 1'b0));
        repeat (5)
            send_segment(build_segment(1'($urandom_range(1)), cfg_port,
                                       6'($urandom_range(63)),
                                       $urandom, $urandom, 16'($urandom),
                                       1'($urandom_range(1))));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset once, walk the lifecycle, then settle and report.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_listen_handshake();
        test_syn_received();
        test_established_pages();
        test_random_traffic();
        test_teardown();

        drain_replies();
        repeat (10) @(posedge clk);
        if (pending_replies.size() != 0)
            note_failure($sformatf("%0d reply beats never arrived",
                                   pending_replies.size()));

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
